// ===== sv/sitoa_pkg.sv =====
// ----------------------------------------------------------------------------
// sitoa_pkg
// shared constants for the signed integer to ascii decimal converter
// ----------------------------------------------------------------------------
package sitoa_pkg;

  localparam int CHAR_W  = 6;
  localparam int DIGIT_W = 4;

  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0]  CHAR_NINE  = 6'd57;

  // shift-add-3 correction
  localparam logic [DIGIT_W-1:0] DAB_THRESH = 4'd5;
  localparam logic [DIGIT_W-1:0] DAB_ADJ    = 4'd3;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'd9;

endpackage

// ===== sv/signed_int_to_ascii_decimal.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_ascii_decimal
// converts a two's complement integer into its decimal text, one ascii
// character per result request, minus sign first, no leading zeros
// ----------------------------------------------------------------------------
//
//  channel  | handshake         | payload
//  ---------+-------------------+-------------------------------------------
//  input    | push / full       | value (VALUE_BITS, signed)
//  result   | empty / pop       | ascii_char (6), last_char (1)
//
//  a value leaves the queue; the converter then sends a minus sign if needed, runs
//  one shift-add-3 step per magnitude bit, drops leading zeros and sends each
//  digit; the single converter takes no new value until its last digit is sent
//  reset (rst, synchronous) empties the front register, queue and converter
//  a stalled result (pop low) holds the converter; the front and queue keep
//  taking up to three further values meanwhile
//
module signed_int_to_ascii_decimal
  import sitoa_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic signed [VALUE_BITS-1:0] value,
  output logic                         empty,
  input  logic                         pop,
  output logic [CHAR_W-1:0]            ascii_char,
  output logic                         last_char
);

  // queue entry: sign flag above the magnitude
  logic                  f_wr;
  logic [VALUE_BITS:0]   f_data;
  logic                  q_full;
  logic                  q_empty;
  logic                  q_pop;
  logic [VALUE_BITS:0]   q_data;

  // front: register the request and split it into sign and magnitude
  sitoa_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .value  (value),
    .f_wr   (f_wr),
    .f_data (f_data),
    .q_full (q_full)
  );

  // two-entry queue decouples the front from the converter
  sitoa_fifo #(
    .WIDTH (VALUE_BITS + 1),
    .DEPTH (2)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (f_wr),
    .wr_data (f_data),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .q_empty (q_empty)
  );

  // back end: binary to bcd, then digits out through the result register
  sitoa_conv #(
    .VALUE_BITS (VALUE_BITS)
  ) u_conv (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .ascii_char (ascii_char),
    .last_char  (last_char)
  );

endmodule

// ===== sv/sitoa_fifo.sv =====
// ----------------------------------------------------------------------------
// sitoa_fifo
// short register queue between the classifying front and the converter
// ----------------------------------------------------------------------------
module sitoa_fifo #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             q_full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             q_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_full  = (count == CNT_W'(DEPTH));
  assign q_empty = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (!q_full || rd_en))
    else $error("sitoa_fifo: write into full queue");

endmodule

// ===== sv/sitoa_front.sv =====
// ----------------------------------------------------------------------------
// sitoa_front
// input stage: takes a value, splits it into sign and magnitude
// ----------------------------------------------------------------------------
module sitoa_front #(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic signed [VALUE_BITS-1:0] value,
  output logic                         f_wr,
  output logic [VALUE_BITS:0]          f_data,
  input  logic                         q_full
);

  logic                  f_valid;
  logic                  f_neg;
  logic [VALUE_BITS-1:0] f_mag;
  logic                  take;

  assign f_wr   = f_valid && !q_full;
  assign full   = f_valid && q_full;
  assign take   = push && !full;
  assign f_data = {f_neg, f_mag};

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (take) begin
      f_valid <= 1'b1;
    end else if (f_wr) begin
      f_valid <= 1'b0;
    end
  end

  // most negative value wraps to its true magnitude as an unsigned word
  always_ff @(posedge clk) begin
    if (take) begin
      f_neg <= value[VALUE_BITS-1];
      f_mag <= value[VALUE_BITS-1] ? (~value + 1'b1) : value;
    end
  end

endmodule

// ===== sv/sitoa_conv.sv =====
// ----------------------------------------------------------------------------
// sitoa_conv
// back end: shift-add-3 conversion then character output register
// ----------------------------------------------------------------------------
module sitoa_conv
  import sitoa_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_empty,
  input  logic [VALUE_BITS:0]     q_data,
  output logic                    q_pop,
  output logic                    empty,
  input  logic                    pop,
  output logic [CHAR_W-1:0]       ascii_char,
  output logic                    last_char
);

  localparam int NDIG  = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BCD_W = NDIG * DIGIT_W;
  localparam int BCW   = $clog2(VALUE_BITS + 1);
  localparam int DCW   = $clog2(NDIG);

  typedef enum logic [2:0] {S_IDLE, S_SIGN, S_DAB, S_SKIP, S_EMIT} state_t;

  state_t                state;
  logic [VALUE_BITS-1:0] mag;
  logic [BCD_W-1:0]      bcd;
  logic [BCD_W-1:0]      bcd_adj;
  logic [BCW-1:0]        bitcnt;
  logic [DCW-1:0]        dcnt;
  logic                  out_valid;
  logic [DIGIT_W-1:0]    top;
  logic                  can_put;
  logic                  put;

  assign q_pop   = (state == S_IDLE) && !q_empty;
  assign empty   = !out_valid;
  assign can_put = !out_valid || pop;
  assign top     = bcd[BCD_W-1 -: DIGIT_W];
  // a character goes into the result register this cycle
  assign put     = can_put && (state == S_SIGN || state == S_EMIT);

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[i*DIGIT_W +: DIGIT_W] = (bcd[i*DIGIT_W +: DIGIT_W] >= DAB_THRESH) ?
        bcd[i*DIGIT_W +: DIGIT_W] + DAB_ADJ : bcd[i*DIGIT_W +: DIGIT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (put) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            mag    <= q_data[VALUE_BITS-1:0];
            bcd    <= '0;
            bitcnt <= BCW'(VALUE_BITS);
            state  <= q_data[VALUE_BITS] ? S_SIGN : S_DAB;
          end
        end
        S_SIGN: begin
          if (can_put) begin
            ascii_char <= CHAR_MINUS;
            last_char  <= 1'b0;
            state      <= S_DAB;
          end
        end
        S_DAB: begin
          bcd    <= {bcd_adj[BCD_W-2:0], mag[VALUE_BITS-1]};
          mag    <= {mag[VALUE_BITS-2:0], 1'b0};
          bitcnt <= bitcnt - 1'b1;
          if (bitcnt == BCW'(1)) begin
            dcnt  <= DCW'(NDIG - 1);
            state <= S_SKIP;
          end
        end
        S_SKIP: begin
          // drop leading zero digits, keeping at least one
          if (top == '0 && dcnt != '0) begin
            bcd  <= {bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            dcnt <= dcnt - 1'b1;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (can_put) begin
            ascii_char <= CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top};
            last_char  <= (dcnt == '0);
            bcd        <= {bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            dcnt       <= dcnt - 1'b1;
            if (dcnt == '0) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ascii_char == CHAR_MINUS ||
                   (ascii_char >= CHAR_ZERO && ascii_char <= CHAR_NINE)))
    else $error("sitoa_conv: character out of range");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ascii_char == CHAR_MINUS) |-> !last_char)
    else $error("sitoa_conv: minus sign flagged as last");

  a_digit_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (top <= DIGIT_MAX))
    else $error("sitoa_conv: bcd digit above nine");

endmodule

// ===== tb/sv/signed_int_to_ascii_decimal_test.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_ascii_decimal_test
// self-checking bench for the signed integer to ascii decimal converter:
// a queue-fed driver sends values in random bursts, a predictor builds the
// expected character runs, and a monitor with its own stall pattern compares
// every character and last flag against them
// ----------------------------------------------------------------------------
module signed_int_to_ascii_decimal_test;
  import sitoa_pkg::*;

  localparam int VALUE_BITS     = 32;
  localparam int SETTLE_CYCLES  = 60;    // a little over one conversion
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no request taken
  localparam int RANDOM_VALUES  = 188;

  // one character of decimal text as it should leave the block
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  // one value waiting to be sent; drain_first holds it back until the
  // block has handed out every character still owed
  typedef struct {
    logic signed [VALUE_BITS-1:0] val;
    bit                           drain_first;
  } value_req_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         push = 1'b0;
  logic                         full;
  logic signed [VALUE_BITS-1:0] value = '0;
  logic                         empty;
  logic                         pop = 1'b0;
  logic [CHAR_W-1:0]            ascii_char;
  logic                         last_char;

  value_req_t pending_values[$];
  text_char_t expected_chars[$];

  int fail_count     = 0;
  int values_sent    = 0;
  int negatives_sent = 0;
  int zeros_sent     = 0;
  int chars_checked  = 0;
  int quiet_cycles   = 0;

  signed_int_to_ascii_decimal #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .value(value),
    .empty(empty),
    .pop(pop),
    .ascii_char(ascii_char),
    .last_char(last_char)
  );

  always #6 clk = ~clk;

  // decimal text of one value: optional minus, then the magnitude's digits
  // most significant first; the most negative value keeps its full magnitude
  // because the unsigned negate of 32'h8000_0000 is itself
  function automatic void predict_text(logic signed [VALUE_BITS-1:0] v);
    logic [VALUE_BITS-1:0] mag;
    logic [DIGIT_W-1:0]    digits[$];
    text_char_t            c;
    mag = v;
    if (v[VALUE_BITS-1]) mag = -mag;
    if (mag == 0) begin
      c.ch   = CHAR_ZERO;
      c.last = 1'b1;
      expected_chars.push_back(c);
      return;
    end
    while (mag != 0) begin
      digits.push_front(DIGIT_W'(mag % 10));
      mag = mag / 10;
    end
    if (v[VALUE_BITS-1]) begin
      // a sign is never the last character
      c.ch   = CHAR_MINUS;
      c.last = 1'b0;
      expected_chars.push_back(c);
    end
    foreach (digits[i]) begin
      c.ch   = CHAR_ZERO + digits[i];
      c.last = (i == digits.size() - 1);
      expected_chars.push_back(c);
    end
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] pow10(int n);
    logic signed [VALUE_BITS-1:0] p;
    p = 1;
    repeat (n) p = p * 10;
    return p;
  endfunction

  // random values spread over digit counts, signs and the awkward corners,
  // with a share of fully random words so every input bit toggles
  function automatic logic signed [VALUE_BITS-1:0] random_value();
    logic signed [VALUE_BITS-1:0] v;
    int                           n;
    case ($urandom_range(0, 5))
      0, 5: v = $urandom;
      1: v = $urandom_range(0, 20);
      2: begin
        n = $urandom_range(1, 10);
        if (n == 10) v = $urandom_range(32'h7fff_ffff, 1_000_000_000);
        else v = $urandom_range(pow10(n) - 1, pow10(n - 1));
      end
      3: begin
        n = $urandom_range(0, 9);
        v = pow10(n) + $urandom_range(0, 2) - 1;
      end
      default: v = 32'h7fff_ffff - $urandom_range(0, 5);
    endcase
    // flip the sign on half of the nonzero values; from the top corner
    // this also lands on the most negative value once the offset wraps
    if (v != 0 && $urandom_range(0, 1)) v = -v - (($urandom_range(0, 7) == 0) ? 1 : 0);
    return v;
  endfunction

  function automatic void queue_value(logic signed [VALUE_BITS-1:0] v, bit drain);
    value_req_t r;
    r.val         = v;
    r.drain_first = drain;
    pending_values.push_back(r);
  endfunction

  // ---------------------------------------------------------------------
  // driver: one request at a time from pending_values, in bursts of random
  // length separated by random gaps; an offered request is held until taken
  // ---------------------------------------------------------------------
  int         burst_left = 1;
  int         gap_left   = 0;
  value_req_t next_req;

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_text(value);
        values_sent++;
        if (value < 0) negatives_sent++;
        if (value == 0) zeros_sent++;
      end
      if (push && full) begin
        // request still waiting, leave push and value alone
      end else if (gap_left > 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (pending_values.size() == 0) begin
        push <= 1'b0;
      end else if (pending_values[0].drain_first && expected_chars.size() != 0) begin
        // hold off until every owed character has come out
        push <= 1'b0;
      end else begin
        next_req = pending_values.pop_front();
        push  <= 1'b1;
        value <= next_req.val;
        burst_left--;
        if (burst_left <= 0) begin
          // a quarter of bursts run straight into the next one
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // monitor: checks each taken character against the oldest expectation;
  // pop follows stall modes that change at random intervals, from
  // never stalling to stalling most of the time
  // ---------------------------------------------------------------------
  int         stall_left = 0;
  int         stall_mode = 0;
  int         mode_left  = 0;
  text_char_t want;

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        chars_checked++;
        if (expected_chars.size() == 0) begin
          $error("unexpected character: ascii_char %0d last_char %0d", ascii_char, last_char);
          fail_count++;
        end else begin
          want = expected_chars.pop_front();
          if (ascii_char !== want.ch) begin
            $error("ascii_char: expected %0d, got %0d", want.ch, ascii_char);
            fail_count++;
          end
          if (last_char !== want.last) begin
            $error("last_char: expected %0d, got %0d", want.last, last_char);
            fail_count++;
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(32, 256);
      end else begin
        mode_left--;
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (stall_mode != 0 && $urandom_range(0, 3) < stall_mode) begin
        stall_left = $urandom_range(0, 11);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog: too long with no request taken on either side ends the run
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin
    // directed: zero, single digits, decade boundaries, both extremes
    // including the most negative value, and alternating bit patterns
    queue_value(0, 1'b0);
    queue_value(1, 1'b0);
    queue_value(-1, 1'b0);
    queue_value(9, 1'b0);
    queue_value(10, 1'b0);
    queue_value(-10, 1'b0);
    queue_value(99, 1'b0);
    queue_value(100, 1'b0);
    queue_value(-7, 1'b0);
    queue_value(32'sh7fff_ffff, 1'b0);
    queue_value(32'sh8000_0000, 1'b0);
    queue_value(32'sh8000_0001, 1'b0);
    queue_value(999_999_999, 1'b0);
    queue_value(1_000_000_000, 1'b0);
    queue_value(-999_999_999, 1'b0);
    queue_value(-1_000_000_000, 1'b0);
    queue_value(1_234_567_890, 1'b0);
    queue_value(-1_234_567_890, 1'b0);
    queue_value(32'sh5555_5555, 1'b0);
    queue_value(32'shaaaa_aaaa, 1'b0);
    queue_value(0, 1'b0);
    queue_value(32'sh8000_0000, 1'b0);

    // random part; the first item and a few later ones wait for a full drain
    for (int i = 0; i < RANDOM_VALUES; i++)
      queue_value(random_value(), i == 0 || i == RANDOM_VALUES / 2 || $urandom_range(0, 49) == 0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending_values.size() != 0 || push || expected_chars.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d values (%0d negative, %0d zero) in random bursts",
             values_sent, negatives_sent, zeros_sent);
    $display("compared %0d characters under varying result stalls", chars_checked);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
